// ===== src/assert_macros.svh =====
// assert_macros.svh
// assertion macros used by the checker file; no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define GHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define GHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gha_pkg.sv =====
// gha_pkg.sv
// shared constants, codes and control structs of the handle allocator
// no dependencies
package gha_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int GEN_W        = 8;
    localparam int SLOT_FIELD_W = 8;
    localparam int HANDLE_W     = GEN_W + SLOT_FIELD_W;
    localparam int MODE_W       = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_REVAL = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NONE  = 2'd3
    } gha_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_GRANT = 5'b00100,
        ST_GEN   = 5'b01000,
        ST_DONE  = 5'b10000
    } gha_state_t;

    typedef struct packed {
        logic capture;
        logic rd_handle;
        logic rd_grant;
        logic write_gen;
        logic res_echo;
        logic res_zero;
        logic load_out;
    } gha_cmd_t;

    typedef struct packed {
        gha_mode_t in_mode;
        logic      in_range;
        logic      gen_match;
        logic      any_free;
        logic      out_free;
    } gha_status_t;

endpackage

// ===== src/gha_ram.sv =====
// gha_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/gha_dpath.sv =====
// gha_dpath.sv
// datapath: busy bits, generation ram with valid bits, result and output register
// depends on gha_pkg and gha_ram
module gha_dpath
    import gha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  gha_cmd_t              cmd,
    output gha_status_t           status,
    input  logic [MODE_W-1:0]     mode,
    input  logic [HANDLE_W-1:0]   handle_in,
    input  logic [HANDLE_W-1:0]   free_mask,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [HANDLE_W-1:0]   handle_out
);

    logic [SLOT_COUNT-1:0]   busy_reg, busy_next;
    logic [SLOT_COUNT-1:0]   gvalid_reg, gvalid_next;
    logic                    rvalid_reg, rvalid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]     handle_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [HANDLE_W-1:0]     result_reg, result_next;
    logic [HANDLE_W-1:0]     handle_out_reg;

    logic [SLOT_FIELD_W-1:0] in_low;
    logic [SLOT_W-1:0]       in_idx;
    logic [SLOT_W-1:0]       free_idx;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    logic [GEN_W-1:0]        rd_data;
    logic [GEN_W-1:0]        gen_eff;
    logic [GEN_W-1:0]        gen_inc;
    logic [SLOT_FIELD_W-1:0] slot_plus;

    // lowest slot whose busy bit is clear
    function automatic logic [SLOT_W-1:0] first_free(input logic [SLOT_COUNT-1:0] busy);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // decode of the incoming handle
    assign in_low   = handle_in[SLOT_FIELD_W-1:0];
    assign in_idx   = SLOT_W'(in_low - SLOT_FIELD_W'(1));
    assign free_idx = first_free(busy_reg);

    // generation store
    assign rd_en   = cmd.rd_handle | cmd.rd_grant;
    assign rd_addr = cmd.rd_handle ? in_idx : free_idx;

    gha_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk     (clk),
        .wr_en   (cmd.write_gen),
        .wr_addr (slot_reg),
        .wr_data (gen_inc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // never written entries read as generation zero
    assign gen_eff   = rvalid_reg ? rd_data : '0;
    assign gen_inc   = gen_eff + GEN_W'(1);
    assign slot_plus = SLOT_FIELD_W'(slot_reg) + SLOT_FIELD_W'(1);

    // status back to the controller
    assign status.in_mode   = gha_mode_t'(mode);
    assign status.in_range  = (in_low != '0) && (in_low <= SLOT_FIELD_W'(SLOT_COUNT));
    assign status.gen_match = (handle_reg[HANDLE_W-1:SLOT_FIELD_W] == gen_eff);
    assign status.any_free  = ~&busy_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // next state of busy and valid bits
    always_comb
    begin
        busy_next   = busy_reg;
        gvalid_next = gvalid_reg;
        rvalid_next = rvalid_reg;
        if (cmd.capture && (gha_mode_t'(mode) == MODE_FREE))
        begin
            busy_next = busy_reg & ~free_mask[SLOT_COUNT-1:0];
        end
        if (cmd.write_gen)
        begin
            busy_next[slot_reg]   = 1'b1;
            gvalid_next[slot_reg] = 1'b1;
        end
        if (rd_en)
        begin
            rvalid_next = gvalid_reg[rd_addr];
        end
    end

    // result selection
    always_comb
    begin
        result_next = result_reg;
        if (cmd.write_gen)
        begin
            result_next = {gen_inc, slot_plus};
        end
        else if (cmd.res_echo)
        begin
            result_next = handle_reg;
        end
        else if (cmd.res_zero)
        begin
            result_next = '0;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            gvalid_reg    <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            gvalid_reg    <= gvalid_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            handle_reg <= handle_in;
        end
        if (cmd.rd_grant)
        begin
            slot_reg <= free_idx;
        end
        result_reg <= result_next;
        if (cmd.load_out)
        begin
            handle_out_reg <= result_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign handle_out = handle_out_reg;

endmodule

// ===== src/gha_ctrl.sv =====
// gha_ctrl.sv
// controller state machine sequencing check, grant and response
// depends on gha_pkg
module gha_ctrl
    import gha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  gha_status_t status,
    output gha_cmd_t    cmd
);

    gha_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (status.in_mode)
                        MODE_ALLOC:
                        begin
                            state_next = ST_GRANT;
                        end
                        MODE_REVAL:
                        begin
                            if (status.in_range)
                            begin
                                cmd.rd_handle = 1'b1;
                                state_next    = ST_CHECK;
                            end
                            else
                            begin
                                state_next = ST_GRANT;
                            end
                        end
                        default:
                        begin
                            cmd.res_zero = 1'b1;
                            state_next   = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (status.gen_match)
                begin
                    cmd.res_echo = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (status.any_free)
                begin
                    cmd.rd_grant = 1'b1;
                    state_next   = ST_GEN;
                end
                else
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_GEN:
            begin
                cmd.write_gen = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== src/generation_handle_allocator.sv =====
// channel  dir  handshake              fields
// in       in   in_valid / in_ready    mode, handle_in, free_mask
// out      out  out_valid / out_ready  handle_out
//
// one item at a time: free or unused go idle, done; allocate idle, grant, gen, done;
// revalidate reads the generation, then idle, check, done on a match, else on to
// grant, gen, done (idle, grant when the slot is out of range); full pool skips gen
// reset clears busy bits and generation valid bits at once, no clearing pass
// a result waits in the output register while the next item is taken, and
// that item's result stalls in the final state until the register is free
// generation_handle_allocator.sv: top level, depends on gha_pkg, gha_ctrl, gha_dpath
module generation_handle_allocator
    import gha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [HANDLE_W-1:0] handle_in,
    input  logic [HANDLE_W-1:0] free_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HANDLE_W-1:0] handle_out
);

    gha_cmd_t    cmd;
    gha_status_t status;

    // sequencer
    gha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot state and result path
    gha_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .handle_in  (handle_in),
        .free_mask  (free_mask),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .handle_out (handle_out)
    );

endmodule

// ===== src/gha_checker.sv =====
// gha_checker.sv
// port level checks of the handle allocator, bound to the top level
// depends on gha_pkg and assert_macros.svh
`include "assert_macros.svh"

module gha_checker
    import gha_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [MODE_W-1:0]   mode,
    input logic                out_valid,
    input logic                out_ready,
    input logic [HANDLE_W-1:0] handle_out
);

    logic                    in_acc;
    logic [SLOT_FIELD_W-1:0] out_slot;
    logic                    is_zero_mode;
    logic                    out_stall;
    logic                    slot_ok;
    logic                    zero_start;

    assign in_acc       = in_valid && in_ready;
    assign out_slot     = handle_out[SLOT_FIELD_W-1:0];
    assign is_zero_mode = (mode == MODE_FREE) || (mode == MODE_NONE);
    assign out_stall    = out_valid && !out_ready;
    assign slot_ok      = (out_slot != '0) && (out_slot <= SLOT_FIELD_W'(SLOT_COUNT));
    assign zero_start   = in_acc && is_zero_mode && !out_valid;

    // a held result keeps its value
    `GHA_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(handle_out), "held result changed")
    // only one item in flight
    `GHA_ASSERT(a_one_item, in_acc |=> !in_ready, "item accepted while busy")
    // a nonzero handle names an existing slot
    `GHA_ASSERT(a_slot_range, out_valid && (handle_out != '0) |-> slot_ok, "slot out of range")
    // free and unused modes taken with no result held answer with zero via the final state
    `GHA_ASSERT(a_free_zero, zero_start |=> ##1 out_valid && (handle_out == '0), "no zero answer")
    // nothing is offered while in reset
    `GHA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result offered during reset")

endmodule

bind generation_handle_allocator gha_checker u_gha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .handle_out (handle_out)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top.sv: self-checking bench for the generation handle allocator
// depends on gha_pkg and generation_handle_allocator; keeps its own mirror of
// the busy bits and generations to predict every handle that comes back
module tb_top
    import gha_pkg::*;
();

    localparam int CHURN_PAIRS    = 260;
    localparam int RAND_PER_PHASE = 265;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 40;

    // one row of the directed table; result is only used where known is set
    typedef struct packed {
        gha_mode_t           op;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] mask;
        logic                known;
        logic [HANDLE_W-1:0] result;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode = MODE_ALLOC;
    logic [HANDLE_W-1:0] handle_in = '0;
    logic [HANDLE_W-1:0] free_mask = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [HANDLE_W-1:0] handle_out;

    // hand-typed expectation that travels with the item on the input side
    logic                fixed_known = 1'b0;
    logic [HANDLE_W-1:0] fixed_handle = '0;

    // mirror of the allocator state
    logic [SLOT_COUNT-1:0] busy_mirror = '0;
    logic [GEN_W-1:0]      gen_mirror [SLOT_COUNT];

    logic [HANDLE_W-1:0] pending_handles [$];
    logic [HANDLE_W-1:0] issued_handles [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int results_checked = 0;
    int mode_counts [4] = '{0, 0, 0, 0};
    int full_hits = 0;
    int regrants = 0;
    int echoes = 0;
    int gen_wraps = 0;

    // directed table, starting from the cleared state after reset
    dir_row_t dir_rows [26] = '{
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b1, 16'h0101},  // first grant after reset
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b1, 16'h0102},
        '{MODE_NONE,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},  // unused mode does nothing
        '{MODE_REVAL, 16'h0101, 16'h0000, 1'b1, 16'h0101},  // live handle echoed
        '{MODE_REVAL, 16'h0000, 16'hFFFF, 1'b1, 16'h0103},  // handle zero regrants
        '{MODE_REVAL, 16'hFF00, 16'h0000, 1'b1, 16'h0104},  // slot field zero
        '{MODE_REVAL, 16'h0011, 16'h0000, 1'b1, 16'h0105},  // slot field past the pool
        '{MODE_REVAL, 16'hFF10, 16'h0000, 1'b1, 16'h0106},  // top slot, stale generation
        '{MODE_REVAL, 16'h0010, 16'h0000, 1'b1, 16'h0010},  // top slot free, generation match
        '{MODE_REVAL, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0107},  // all ones
        '{MODE_REVAL, 16'h0201, 16'h0000, 1'b1, 16'h0108},  // stale generation
        '{MODE_FREE,  16'h0000, 16'h0000, 1'b1, 16'h0000},  // empty mask
        '{MODE_FREE,  16'hFFFF, 16'h0001, 1'b1, 16'h0000},
        '{MODE_REVAL, 16'h0101, 16'h0000, 1'b1, 16'h0101},  // matching handle on a freed slot
        '{MODE_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0201},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},  // fill the rest of the pool
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{MODE_ALLOC, 16'h0000, 16'h0000, 1'b1, 16'h0000},  // pool full
        '{MODE_REVAL, 16'h0301, 16'h0000, 1'b1, 16'h0000},  // stale handle with pool full
        '{MODE_FREE,  16'h0000, 16'hFFFF, 1'b1, 16'h0000}   // free everything
    };

    generation_handle_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .handle_in  (handle_in),
        .free_mask  (free_mask),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .handle_out (handle_out)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #2_000_000;
        $display("generation_handle_allocator: mismatch");
        $finish;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(string what, logic [HANDLE_W-1:0] got,
                                   logic [HANDLE_W-1:0] want);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: %s: handle_out %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // lowest free slot gets the next generation
    function automatic logic [HANDLE_W-1:0] grant_lowest();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!busy_mirror[i])
            begin
                busy_mirror[i] = 1'b1;
                if (gen_mirror[i] == '1)
                    gen_wraps++;
                gen_mirror[i] = gen_mirror[i] + 1'b1;
                return {gen_mirror[i], 8'(i + 1)};
            end
        end
        full_hits++;
        return '0;
    endfunction

    // handle expected for one accepted item, updating the mirror
    function automatic logic [HANDLE_W-1:0] predict_handle(gha_mode_t op,
                                                           logic [HANDLE_W-1:0] h,
                                                           logic [HANDLE_W-1:0] fm);
        int slot_field;
        slot_field = int'(h[SLOT_FIELD_W-1:0]);
        case (op)
            MODE_ALLOC:
                return grant_lowest();
            MODE_REVAL:
            begin
                // only the generation is compared, busy is not looked at
                if (slot_field != 0 && slot_field <= SLOT_COUNT &&
                    gen_mirror[slot_field - 1] == h[HANDLE_W-1:SLOT_FIELD_W])
                begin
                    echoes++;
                    return h;
                end
                regrants++;
                return grant_lowest();
            end
            MODE_FREE:
            begin
                busy_mirror &= ~fm[SLOT_COUNT-1:0];
                return '0;
            end
            default:
                return '0;
        endcase
    endfunction

    // check results, then predict for the item taken at this edge
    always @(posedge clk)
    begin : watch
        logic [HANDLE_W-1:0] want;
        logic [HANDLE_W-1:0] predicted;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_handles.size() == 0)
                    report_mismatch("result with no item pending", handle_out, '0);
                else
                begin
                    want = pending_handles.pop_front();
                    if (handle_out !== want)
                        report_mismatch("wrong handle", handle_out, want);
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = predict_handle(gha_mode_t'(mode), handle_in, free_mask);
                pending_handles.push_back(fixed_known ? fixed_handle : predicted);
                mode_counts[mode]++;
                if (predicted != '0)
                begin
                    issued_handles.push_back(predicted);
                    if (issued_handles.size() > 32)
                        void'(issued_handles.pop_front());
                end
            end
        end
    end

    // present one item and hold it until taken; returns at the accepting edge
    task automatic send_item(gha_mode_t op, logic [HANDLE_W-1:0] h,
                             logic [HANDLE_W-1:0] fm, logic known,
                             logic [HANDLE_W-1:0] fixed);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op;
        handle_in    <= h;
        free_mask    <= fm;
        fixed_known  <= known;
        fixed_handle <= fixed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // random item, mostly plausible handles and masks
    task automatic send_random_item();
        int                  pick;
        int                  slot;
        gha_mode_t           op;
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] fm;
        pick = $urandom_range(99);
        h    = 16'($urandom);
        fm   = 16'($urandom);
        if (pick < 35)
            op = MODE_ALLOC;
        else if (pick < 70)
            op = MODE_REVAL;
        else if (pick < 95)
            op = MODE_FREE;
        else
            op = MODE_NONE;
        // revalidate: recent handles, near-miss generations, or noise
        if (op == MODE_REVAL)
        begin
            pick = $urandom_range(99);
            if (pick < 45 && issued_handles.size() != 0)
                h = issued_handles[$urandom_range(issued_handles.size() - 1)];
            else if (pick < 70)
            begin
                slot = $urandom_range(SLOT_COUNT - 1);
                h    = {gen_mirror[slot] + 8'($urandom_range(2)), 8'(slot + 1)};
            end
        end
        // free: single slots, sparse or dense masks, all or nothing
        if (op == MODE_FREE)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                fm = 16'(1) << $urandom_range(15);
            else if (pick < 60)
                fm = fm & 16'($urandom);
            else if (pick < 70)
                fm = '1;
            else if (pick < 75)
                fm = '0;
        end
        send_item(op, h, fm, 1'b0, '0);
    endtask

    // hold off the sender until every pending result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_handles.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int idle_plan [4];
        int stall_plan [4];
        rst_n      <= 1'b0;
        idle_plan  = '{0, 72, 0, 26};
        stall_plan = '{0, 0, 72, 26};
        for (int i = 0; i < SLOT_COUNT; i++)
            gen_mirror[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].handle, dir_rows[i].mask,
                      dir_rows[i].known, dir_rows[i].result);

        // grant and free slot 0 until its generation wraps
        for (int n = 0; n < CHURN_PAIRS; n++)
        begin
            send_item(MODE_ALLOC, 16'($urandom), 16'($urandom), 1'b0, '0);
            send_item(MODE_FREE, 16'($urandom), 16'h0001, 1'b0, '0);
        end

        // random phases with different idle and stall rates
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  <= idle_plan[p];
            stall_pct <= stall_plan[p];
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_random_item();
            drain();
        end

        stall_pct <= 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("items: %0d allocate, %0d revalidate, %0d free, %0d unused; %0d checked",
                 mode_counts[MODE_ALLOC], mode_counts[MODE_REVAL],
                 mode_counts[MODE_FREE], mode_counts[MODE_NONE], results_checked);
        $display("pool full %0d times, %0d echoed handles, %0d regrants, %0d generation wraps",
                 full_hits, echoes, regrants, gen_wraps);
        if (fail_count == 0)
            $display("generation_handle_allocator: match");
        else
            $display("generation_handle_allocator: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/gha_pkg.sv
src/gha_ram.sv
src/gha_dpath.sv
src/gha_ctrl.sv
src/generation_handle_allocator.sv
src/gha_checker.sv
dv/tb_top.sv
